@@ hw/rtl/nlp_pkg.sv @@
`default_nettype none

package nlp_pkg;

  localparam int VALUE_BITS = 16;

  // ASCII codes
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_H  = 8'h48;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_H  = 8'h68;
  localparam logic [7:0] CH_LO_X  = 8'h78;

  // prefix codes
  localparam logic [1:0] PFX_NONE = 2'd0;
  localparam logic [1:0] PFX_BIN  = 2'd1;
  localparam logic [1:0] PFX_HEX  = 2'd2;

  // radix codes on the result
  localparam logic [1:0] RADIX_BIN = 2'd0;
  localparam logic [1:0] RADIX_DEC = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  // bit positions in the stop flags
  localparam int STOP_BIN = 0;
  localparam int STOP_DEC = 1;
  localparam int STOP_HEX = 2;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } char_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [1:0]            radix_used;
  } result_t;

  typedef struct packed {
    logic [2:0]            stop;
    logic [VALUE_BITS-1:0] bin;
    logic [VALUE_BITS-1:0] dec;
    logic [VALUE_BITS-1:0] hex;
  } acc_t;

  // Push one character into all three accumulators; a radix freezes at its
  // first character that is not one of its digits.
  function automatic acc_t feed(acc_t a, logic [7:0] c);
    acc_t       r;
    logic [3:0] h;
    logic       hv;
    r  = a;
    h  = c[3:0];
    hv = 1'b1;
    if (c inside {[CH_0:CH_9]}) begin
      h = c[3:0];
    end else if ((c inside {[CH_UP_A:CH_UP_F]}) || (c inside {[CH_LO_A:CH_LO_F]})) begin
      h = c[3:0] + 4'd9;
    end else begin
      hv = 1'b0;
    end
    if (!a.stop[STOP_BIN]) begin
      if (c == CH_0 || c == CH_1) begin
        r.bin = {a.bin[VALUE_BITS-2:0], c[0]};
      end else begin
        r.stop[STOP_BIN] = 1'b1;
      end
    end
    if (!a.stop[STOP_DEC]) begin
      if (c inside {[CH_0:CH_9]}) begin
        r.dec = (a.dec << 3) + (a.dec << 1) + {{(VALUE_BITS-4){1'b0}}, c[3:0]};
      end else begin
        r.stop[STOP_DEC] = 1'b1;
      end
    end
    if (!a.stop[STOP_HEX]) begin
      if (hv) begin
        r.hex = {a.hex[VALUE_BITS-5:0], h};
      end else begin
        r.stop[STOP_HEX] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/number_literal_parser.sv @@
// Numeric literal parser.
// Input channel char_valid / char_stall / char_item carries one ASCII
// character per item; last_char marks the end of a literal. The radix comes
// from a 0x/0b prefix or an h/b suffix (dropped), else decimal.
// Output channel result_valid / result_stall / result_item carries one item
// per literal: value (wrapping 16 bits) and radix_used (0 bin, 1 dec, 2 hex).
// Throughput: one character per cycle while not stalled. The per-character
// update (shift, multiply by ten, add) sits between the state registers and the
// result register, so a result appears in the cycle after its last character.
// The result register is the only buffer: while it holds an item and the
// receiver stalls, char_stall is high and the parser holds its state.
// Once the receiver takes the item, a new character is accepted in that
// same cycle.
// Reset (rst, synchronous) clears the parse state and empties the result
// register. Parse state also returns to reset after every literal.
`default_nettype none

module number_literal_parser (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 char_valid,
  output logic                char_stall,
  input  wire nlp_pkg::char_t char_item,
  output logic                result_valid,
  input  wire                 result_stall,
  output nlp_pkg::result_t    result_item
);

  logic [1:0]      position;
  logic [7:0]      held_char;
  logic [1:0]      prefix_mode;
  nlp_pkg::acc_t   acc;

  logic            accept;
  logic [7:0]      c;
  logic            pfx;
  logic            det_hex;
  logic            det_bin;
  logic            do_feed;
  nlp_pkg::acc_t   acc_a;
  nlp_pkg::acc_t   acc_b;
  logic [1:0]      prefix_a;
  logic [7:0]      held_a;
  nlp_pkg::result_t result_next;

  assign char_stall = result_valid && result_stall;
  assign accept     = char_valid && !char_stall;
  assign c          = char_item.char_code;

  always_comb begin
    pfx     = (prefix_mode == nlp_pkg::PFX_BIN) || (prefix_mode == nlp_pkg::PFX_HEX);
    det_hex = !pfx && position == 2'd1 && held_char == nlp_pkg::CH_0 &&
              (c == nlp_pkg::CH_UP_X || c == nlp_pkg::CH_LO_X);
    det_bin = !pfx && position == 2'd1 && held_char == nlp_pkg::CH_0 &&
              (c == nlp_pkg::CH_UP_B || c == nlp_pkg::CH_LO_B);
    // in prefix mode use the fresh char, else the one held back
    do_feed = pfx || (!det_hex && !det_bin && position != 2'd0);
    acc_a   = do_feed ? nlp_pkg::feed(acc, pfx ? c : held_char) : acc;
    prefix_a = det_hex ? nlp_pkg::PFX_HEX : (det_bin ? nlp_pkg::PFX_BIN : prefix_mode);
    held_a   = (!pfx && !det_hex && !det_bin) ? c : held_char;
    // decimal ending: the final char is a digit too
    acc_b   = nlp_pkg::feed(acc_a, c);

    if (prefix_a == nlp_pkg::PFX_HEX) begin
      result_next.value      = acc_a.hex;
      result_next.radix_used = nlp_pkg::RADIX_HEX;
    end else if (prefix_a == nlp_pkg::PFX_BIN) begin
      result_next.value      = acc_a.bin;
      result_next.radix_used = nlp_pkg::RADIX_BIN;
    end else if (c == nlp_pkg::CH_UP_H || c == nlp_pkg::CH_LO_H) begin
      result_next.value      = acc_a.hex;
      result_next.radix_used = nlp_pkg::RADIX_HEX;
    end else if (c == nlp_pkg::CH_UP_B || c == nlp_pkg::CH_LO_B) begin
      result_next.value      = acc_a.bin;
      result_next.radix_used = nlp_pkg::RADIX_BIN;
    end else begin
      result_next.value      = acc_b.dec;
      result_next.radix_used = nlp_pkg::RADIX_DEC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= 2'd0;
      held_char    <= 8'd0;
      prefix_mode  <= nlp_pkg::PFX_NONE;
      acc          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (char_item.last_char) begin
          position    <= 2'd0;
          held_char   <= 8'd0;
          prefix_mode <= nlp_pkg::PFX_NONE;
          acc         <= '0;
        end else begin
          position    <= (position < 2'd2) ? position + 2'd1 : position;
          held_char   <= held_a;
          prefix_mode <= prefix_a;
          acc         <= acc_a;
        end
      end
      if (accept && char_item.last_char) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // load the result only when the register is free or draining
  always_ff @(posedge clk) begin
    if (accept && char_item.last_char) begin
      result_item <= result_next;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> result_valid)
    else $error("input stalled with empty result register");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (accept && char_item.last_char) |=> result_valid)
    else $error("last char did not produce a result");

  a_no_extra_result: assert property (@(posedge clk) disable iff (rst)
    (!(accept && char_item.last_char) && !(result_valid && result_stall)) |=> !result_valid)
    else $error("result appeared without a last char");

  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    (accept && char_item.last_char) |=>
      (position == 2'd0 && prefix_mode == nlp_pkg::PFX_NONE && acc.stop == 3'd0))
    else $error("parse state not cleared after literal");

  a_position_bound: assert property (@(posedge clk) disable iff (rst)
    position != 2'd3)
    else $error("position passed saturation");

endmodule

`default_nettype wire

@@ verif/number_literal_parser_tb.sv @@
module number_literal_parser_tb;

  typedef logic [7:0] text_t[$];

  // Tracks the parse of the current literal and holds the results it owes.
  class literal_scoreboard;
    logic [1:0]                    position;
    logic [7:0]                    held_back;
    logic [1:0]                    prefix;
    logic [nlp_pkg::VALUE_BITS-1:0] bin_val;
    logic [nlp_pkg::VALUE_BITS-1:0] dec_val;
    logic [nlp_pkg::VALUE_BITS-1:0] hex_val;
    logic [2:0]                    frozen;
    nlp_pkg::result_t              expected_results[$];
    int                            errors;
    int                            results_seen;

    function new();
      clear();
      errors = 0;
      results_seen = 0;
    endfunction

    function void clear();
      position  = 2'd0;
      held_back = 8'd0;
      prefix    = nlp_pkg::PFX_NONE;
      bin_val   = '0;
      dec_val   = '0;
      hex_val   = '0;
      frozen    = 3'b000;
    endfunction

    function void shift_in_digit(logic [7:0] c);
      logic [31:0] sum;
      logic [7:0]  d;
      logic        is_hex;
      is_hex = 1'b1;
      d = 8'd0;
      if (c >= nlp_pkg::CH_0 && c <= nlp_pkg::CH_9) begin
        d = c - nlp_pkg::CH_0;
      end else if (c >= nlp_pkg::CH_UP_A && c <= nlp_pkg::CH_UP_F) begin
        d = c - nlp_pkg::CH_UP_A + 8'd10;
      end else if (c >= nlp_pkg::CH_LO_A && c <= nlp_pkg::CH_LO_F) begin
        d = c - nlp_pkg::CH_LO_A + 8'd10;
      end else begin
        is_hex = 1'b0;
      end
      if (!frozen[nlp_pkg::STOP_BIN]) begin
        if (c == nlp_pkg::CH_0 || c == nlp_pkg::CH_1) begin
          bin_val = {bin_val[nlp_pkg::VALUE_BITS-2:0], c == nlp_pkg::CH_1};
        end else begin
          frozen[nlp_pkg::STOP_BIN] = 1'b1;
        end
      end
      if (!frozen[nlp_pkg::STOP_DEC]) begin
        if (c >= nlp_pkg::CH_0 && c <= nlp_pkg::CH_9) begin
          sum = dec_val * 32'd10 + d;
          dec_val = sum[nlp_pkg::VALUE_BITS-1:0];
        end else begin
          frozen[nlp_pkg::STOP_DEC] = 1'b1;
        end
      end
      if (!frozen[nlp_pkg::STOP_HEX]) begin
        if (is_hex) begin
          hex_val = {hex_val[nlp_pkg::VALUE_BITS-5:0], d[3:0]};
        end else begin
          frozen[nlp_pkg::STOP_HEX] = 1'b1;
        end
      end
    endfunction

    function void note_char(nlp_pkg::char_t ch);
      logic [7:0]       c;
      nlp_pkg::result_t r;
      c = ch.char_code;
      if (prefix == nlp_pkg::PFX_BIN || prefix == nlp_pkg::PFX_HEX) begin
        shift_in_digit(c);
      end else if (position == 2'd1 && held_back == nlp_pkg::CH_0 &&
                   (c == nlp_pkg::CH_UP_X || c == nlp_pkg::CH_LO_X)) begin
        prefix = nlp_pkg::PFX_HEX;
      end else if (position == 2'd1 && held_back == nlp_pkg::CH_0 &&
                   (c == nlp_pkg::CH_UP_B || c == nlp_pkg::CH_LO_B)) begin
        prefix = nlp_pkg::PFX_BIN;
      end else begin
        // the held character is known not to be a suffix now
        if (position != 2'd0) shift_in_digit(held_back);
        held_back = c;
      end
      if (!ch.last_char) begin
        if (position < 2'd2) position++;
        return;
      end
      if (prefix == nlp_pkg::PFX_HEX) begin
        r.value = hex_val;
        r.radix_used = nlp_pkg::RADIX_HEX;
      end else if (prefix == nlp_pkg::PFX_BIN) begin
        r.value = bin_val;
        r.radix_used = nlp_pkg::RADIX_BIN;
      end else if (c == nlp_pkg::CH_LO_H || c == nlp_pkg::CH_UP_H) begin
        r.value = hex_val;
        r.radix_used = nlp_pkg::RADIX_HEX;
      end else if (c == nlp_pkg::CH_LO_B || c == nlp_pkg::CH_UP_B) begin
        r.value = bin_val;
        r.radix_used = nlp_pkg::RADIX_BIN;
      end else begin
        shift_in_digit(c);
        r.value = dec_val;
        r.radix_used = nlp_pkg::RADIX_DEC;
      end
      expected_results.push_back(r);
      clear();
    endfunction

    function void check_result(nlp_pkg::result_t got);
      nlp_pkg::result_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result value %h radix %0d", $time, got.value,
                 got.radix_used);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.value !== want.value) begin
        $display("%0t: value expected %h actual %h", $time, want.value, got.value);
        errors++;
      end
      if (got.radix_used !== want.radix_used) begin
        $display("%0t: radix expected %0d actual %0d", $time, want.radix_used,
                 got.radix_used);
        errors++;
      end
    endfunction

    function void close();
      if (expected_results.size() != 0) begin
        $display("%0t: %0d results never arrived", $time, expected_results.size());
        errors++;
      end
    endfunction
  endclass

  localparam int NUM_CHARS = 1600;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             char_valid = 1'b0;
  logic             char_stall;
  nlp_pkg::char_t   char_item = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  nlp_pkg::result_t result_item;

  literal_scoreboard sb = new();
  int  chars_sent = 0;
  int  send_idle_pct = 38;
  int  recv_idle_pct = 76;
  bit  held_off = 1'b0;

  number_literal_parser u_top (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_item    (char_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    nlp_pkg::char_t it;
    it.char_code = c;
    it.last_char = last;
    while ($urandom_range(99) < send_idle_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_item  <= it;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    sb.note_char(it);
    chars_sent++;
  endtask

  task automatic send_text(input text_t t);
    foreach (t[i]) send_char(t[i], i == t.size() - 1);
  endtask

  function automatic text_t to_text(string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  function automatic logic [7:0] any_hex_digit();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(21)];
  endfunction

  function automatic text_t random_literal();
    text_t t;
    int    kind;
    int    n;
    kind = $urandom_range(99);
    if (kind < 18) begin
      t.push_back(nlp_pkg::CH_0);
      t.push_back($urandom_range(1) ? nlp_pkg::CH_UP_X : nlp_pkg::CH_LO_X);
      n = $urandom_range(6);
      repeat (n) t.push_back(any_hex_digit());
    end else if (kind < 32) begin
      t.push_back(nlp_pkg::CH_0);
      t.push_back($urandom_range(1) ? nlp_pkg::CH_UP_B : nlp_pkg::CH_LO_B);
      n = $urandom_range(17);
      repeat (n) t.push_back($urandom_range(1) ? nlp_pkg::CH_1 : nlp_pkg::CH_0);
    end else if (kind < 48) begin
      n = $urandom_range(6);
      repeat (n) t.push_back(any_hex_digit());
      t.push_back($urandom_range(1) ? nlp_pkg::CH_UP_H : nlp_pkg::CH_LO_H);
    end else if (kind < 62) begin
      n = $urandom_range(17);
      repeat (n) t.push_back($urandom_range(1) ? nlp_pkg::CH_1 : nlp_pkg::CH_0);
      t.push_back($urandom_range(1) ? nlp_pkg::CH_UP_B : nlp_pkg::CH_LO_B);
    end else if (kind < 80) begin
      n = $urandom_range(7, 1);
      repeat (n) t.push_back(nlp_pkg::CH_0 + 8'($urandom_range(9)));
    end else if (kind < 90) begin
      n = $urandom_range(6, 1);
      repeat (n) t.push_back(8'($urandom_range(255)));
    end else begin
      // well-formed hex literal with one character spoiled
      n = $urandom_range(5, 1);
      repeat (n) t.push_back(any_hex_digit());
      t.push_back(nlp_pkg::CH_LO_H);
      t[$urandom_range(t.size() - 1)] = 8'($urandom_range(255));
    end
    return t;
  endfunction

  always begin
    if (!held_off && sb.results_seen >= 40) begin
      // hold off long enough for the block to fill and stall its input
      held_off = 1'b1;
      result_stall <= 1'b1;
      repeat (150) @(posedge clk);
    end
    result_stall <= ($urandom_range(99) < recv_idle_pct);
    @(posedge clk);
    if (!rst && result_valid && !result_stall) sb.check_result(result_item);
  end

  initial begin
    string directed[$];
    int    waited;
    directed = '{"0x", "0b", "h", "b", "0XfF", "1aH", "0B1z1", "1Ah", "101B",
                 "99999", "0"};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_text(to_text(directed[i]));
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    for (int stage = 0; stage < 3; stage++) begin
      send_idle_pct = (stage == 0) ? 38 : (stage == 1) ? 76 : 0;
      recv_idle_pct = (stage == 0) ? 76 : (stage == 1) ? 38 : 0;
      while (chars_sent < (stage + 1) * NUM_CHARS / 3) send_text(random_literal());
    end
    char_valid <= 1'b0;
    waited = 0;
    while (sb.expected_results.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (5) @(posedge clk);
    sb.close();
    if (sb.errors == 0) begin
      $display("number_literal_parser regression: pass");
    end else begin
      $display("number_literal_parser regression: fail");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("number_literal_parser regression: fail");
    $finish;
  end

endmodule
